/* design/pcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types, widths and code tables for the popup placement core.
// ----------------------------------------------------------------------------
package pcp_pkg;

    // internal working width, holds every intermediate coordinate exactly
    localparam int CW = 21;
    localparam int OW = 18;

    typedef logic signed [CW-1:0] t_val;

    // placement codes
    localparam logic [3:0] PC_NONE = 4'd0;
    localparam logic [3:0] PC_TOP  = 4'd1;
    localparam logic [3:0] PC_BOT  = 4'd2;
    localparam logic [3:0] PC_LEFT = 4'd3;
    localparam logic [3:0] PC_RGT  = 4'd4;
    localparam logic [3:0] PC_TL   = 4'd5;
    localparam logic [3:0] PC_BL   = 4'd6;
    localparam logic [3:0] PC_TR   = 4'd7;
    localparam logic [3:0] PC_BR   = 4'd8;

    // config register indexes
    localparam logic [1:0] REG_BX = 2'd0;
    localparam logic [1:0] REG_BY = 2'd1;
    localparam logic [1:0] REG_BW = 2'd2;
    localparam logic [1:0] REG_BH = 2'd3;

    // offset along one axis: none, half of the size, whole size
    typedef enum logic [1:0] {
        OFF_ZERO = 2'd0,
        OFF_HALF = 2'd1,
        OFF_FULL = 2'd2
    } t_off;

    typedef struct packed {
        logic flip;
        logic slide;
        logic resize;
    } t_adj;

    // outcome of the constraint pass on one axis
    typedef enum logic [2:0] {
        K_KEEP     = 3'd0,
        K_FLIP     = 3'd1,
        K_SLIDE_LO = 3'd2,
        K_SLIDE_HI = 3'd3,
        K_RSZ_SLD  = 3'd4,
        K_RSZ_HI   = 3'd5
    } t_kind;

    // half, truncated toward zero
    function automatic t_val half_tz(input t_val v);
        t_val t;
        t = v + t_val'(v < 0);
        return t >>> 1;
    endfunction

    function automatic t_val off_val(input t_off sel, input t_val v);
        t_val r;
        case (sel)
            OFF_HALF: r = half_tz(v);
            OFF_FULL: r = v;
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] flip_x(input logic [3:0] c);
        logic [3:0] r;
        case (c)
            PC_LEFT: r = PC_RGT;
            PC_RGT:  r = PC_LEFT;
            PC_TL:   r = PC_TR;
            PC_TR:   r = PC_TL;
            PC_BL:   r = PC_BR;
            PC_BR:   r = PC_BL;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] flip_y(input logic [3:0] c);
        logic [3:0] r;
        case (c)
            PC_TOP:  r = PC_BOT;
            PC_BOT:  r = PC_TOP;
            PC_TL:   r = PC_BL;
            PC_BL:   r = PC_TL;
            PC_TR:   r = PC_BR;
            PC_BR:   r = PC_TR;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic t_off anc_x(input logic [3:0] c);
        t_off r;
        case (c)
            PC_NONE, PC_TOP, PC_BOT: r = OFF_HALF;
            PC_RGT, PC_TR, PC_BR:    r = OFF_FULL;
            default:                 r = OFF_ZERO;
        endcase
        return r;
    endfunction

    function automatic t_off anc_y(input logic [3:0] c);
        t_off r;
        case (c)
            PC_NONE, PC_LEFT, PC_RGT: r = OFF_HALF;
            PC_BOT, PC_BL, PC_BR:     r = OFF_FULL;
            default:                  r = OFF_ZERO;
        endcase
        return r;
    endfunction

    function automatic t_off grv_x(input logic [3:0] c);
        t_off r;
        case (c)
            PC_NONE, PC_TOP, PC_BOT: r = OFF_HALF;
            PC_LEFT, PC_TL, PC_BL:   r = OFF_FULL;
            default:                 r = OFF_ZERO;
        endcase
        return r;
    endfunction

    function automatic t_off grv_y(input logic [3:0] c);
        t_off r;
        case (c)
            PC_NONE, PC_LEFT, PC_RGT: r = OFF_HALF;
            PC_TOP, PC_TL, PC_TR:     r = OFF_FULL;
            default:                  r = OFF_ZERO;
        endcase
        return r;
    endfunction

endpackage

/* design/popup_constraint_placement_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popup_constraint_placement_core
// Places a popup against an anchor rectangle and fits it into the bounds.
// ----------------------------------------------------------------------------
// Each input word is one placement request; each output word is the final
// popup rectangle relative to the parent. The core is a four-stage pipeline
// (offsets, candidate positions, edge checks and decision, resize and final
// subtract) with an X and a Y datapath side by side, so a new word is taken
// every cycle unless a held result stalls the pipeline. The whole pipeline
// holds while a finished result waits under output stall. The bounds
// registers are written through the config port, which is always ready;
// write them only while no request is in flight.
// ----------------------------------------------------------------------------
module popup_constraint_placement_core import pcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic        [1:0]    i_cfg_index,
    input  logic        [15:0]   i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_parent_x,
    input  logic signed [15:0]   i_parent_y,
    input  logic signed [15:0]   i_anchor_rect_x,
    input  logic signed [15:0]   i_anchor_rect_y,
    input  logic        [14:0]   i_anchor_rect_w,
    input  logic        [14:0]   i_anchor_rect_h,
    input  logic signed [15:0]   i_offset_x,
    input  logic signed [15:0]   i_offset_y,
    input  logic        [14:0]   i_popup_w,
    input  logic        [14:0]   i_popup_h,
    input  logic        [7:0]    i_placement_codes,
    input  logic        [5:0]    i_adjust_flags,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [OW-1:0] o_rect_x,
    output logic signed [OW-1:0] o_rect_y,
    output logic signed [OW-1:0] o_rect_w,
    output logic signed [OW-1:0] o_rect_h
);

    // bounds registers
    logic signed [15:0] r_bx, r_by;
    logic        [15:0] r_bw, r_bh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx <= '0;
            r_by <= '0;
            r_bw <= '0;
            r_bh <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BX:  r_bx <= i_cfg_data;
                REG_BY:  r_by <= i_cfg_data;
                REG_BW:  r_bw <= i_cfg_data;
                REG_BH:  r_bh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the result register is full and stalled
    logic       en;
    logic [3:0] r_vld;

    assign en          = !(r_vld[3] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_in_valid};
        end
    end

    // code decode; an X flip only moves the horizontal part and a Y flip the
    // vertical part, so the two axes resolve independently
    logic [3:0] anc, grv;
    t_adj       adj_x, adj_y;

    assign anc   = i_placement_codes[3:0];
    assign grv   = i_placement_codes[7:4];
    assign adj_x = '{flip: i_adjust_flags[2], slide: i_adjust_flags[0],
                     resize: i_adjust_flags[4]};
    assign adj_y = '{flip: i_adjust_flags[3], slide: i_adjust_flags[1],
                     resize: i_adjust_flags[5]};

    pcp_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_parent (i_parent_x),
        .i_arect  (i_anchor_rect_x),
        .i_offset (i_offset_x),
        .i_asize  (i_anchor_rect_w),
        .i_size   (i_popup_w),
        .i_asel   (anc_x(anc)),
        .i_asel_f (anc_x(flip_x(anc))),
        .i_gsel   (grv_x(grv)),
        .i_gsel_f (grv_x(flip_x(grv))),
        .i_adj    (adj_x),
        .i_bound  (r_bx),
        .i_bsize  (r_bw),
        .o_pos    (o_rect_x),
        .o_size   (o_rect_w)
    );

    pcp_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_parent (i_parent_y),
        .i_arect  (i_anchor_rect_y),
        .i_offset (i_offset_y),
        .i_asize  (i_anchor_rect_h),
        .i_size   (i_popup_h),
        .i_asel   (anc_y(anc)),
        .i_asel_f (anc_y(flip_y(anc))),
        .i_gsel   (grv_y(grv)),
        .i_gsel_f (grv_y(flip_y(grv))),
        .i_adj    (adj_y),
        .i_bound  (r_by),
        .i_bsize  (r_bh),
        .o_pos    (o_rect_y),
        .o_size   (o_rect_h)
    );

endmodule

/* design/pcp_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_axis
// Four-stage placement datapath for one axis: position, flip, slide, resize.
// ----------------------------------------------------------------------------
module pcp_axis import pcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_parent,
    input  logic signed [15:0]   i_arect,
    input  logic signed [15:0]   i_offset,
    input  logic        [14:0]   i_asize,
    input  logic        [14:0]   i_size,
    input  t_off                 i_asel,
    input  t_off                 i_asel_f,
    input  t_off                 i_gsel,
    input  t_off                 i_gsel_f,
    input  t_adj                 i_adj,
    input  logic signed [15:0]   i_bound,
    input  logic        [15:0]   i_bsize,
    output logic signed [OW-1:0] o_pos,
    output logic signed [OW-1:0] o_size
);

    t_val c_b, c_bw, c_bhi, c_as, c_w;
    logic c_bon;

    assign c_b   = CW'(i_bound);
    assign c_bw  = CW'(i_bsize);
    assign c_bhi = c_b + c_bw;
    assign c_bon = (i_bsize != '0);
    assign c_as  = CW'(i_asize);
    assign c_w   = CW'(i_size);

    // stage 1: base, anchor and gravity offsets
    t_val r1_base, r1_ao, r1_aof, r1_go, r1_gof, r1_gbw, r1_w, r1_p;
    t_off r1_gsel;
    t_adj r1_adj;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base <= CW'(i_parent) + CW'(i_arect) + CW'(i_offset);
            r1_ao   <= off_val(i_asel, c_as);
            r1_aof  <= off_val(i_asel_f, c_as);
            r1_go   <= off_val(i_gsel, c_w);
            r1_gof  <= off_val(i_gsel_f, c_w);
            r1_gbw  <= off_val(i_gsel, c_bw);
            r1_w    <= c_w;
            r1_p    <= CW'(i_parent);
            r1_gsel <= i_gsel;
            r1_adj  <= i_adj;
        end
    end

    // stage 2: placed and flipped positions
    t_val r2_pos0, r2_pos1, r2_baseao, r2_rsz, r2_w, r2_p;
    t_off r2_gsel;
    t_adj r2_adj;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pos0   <= r1_base + r1_ao - r1_go;
            r2_pos1   <= r1_base + r1_aof - r1_gof;
            r2_baseao <= r1_base + r1_ao;
            r2_rsz    <= c_b + r1_go - r1_gbw;
            r2_w      <= r1_w;
            r2_p      <= r1_p;
            r2_gsel   <= r1_gsel;
            r2_adj    <= r1_adj;
        end
    end

    // stage 3: edge checks and decision
    logic  lo0, hi0, lo1, hi1;
    t_kind n_kind;

    always_comb begin
        lo0 = c_bon && (r2_pos0 < c_b);
        hi0 = c_bon && ((r2_pos0 + r2_w) > c_bhi);
        lo1 = c_bon && (r2_pos1 < c_b);
        hi1 = c_bon && ((r2_pos1 + r2_w) > c_bhi);
        if (!(lo0 || hi0)) begin
            n_kind = K_KEEP;
        end else if (r2_adj.flip && !(lo1 || hi1)) begin
            n_kind = K_FLIP;
        end else if (r2_adj.slide && !(lo0 && hi0) && (r2_w <= c_bw)) begin
            n_kind = lo0 ? K_SLIDE_LO : K_SLIDE_HI;
        end else if (r2_adj.resize && r2_adj.slide) begin
            n_kind = K_RSZ_SLD;
        end else if (r2_adj.resize && hi0) begin
            n_kind = K_RSZ_HI;
        end else begin
            n_kind = K_KEEP;
        end
    end

    t_val  r3_pos0, r3_pos1, r3_baseao, r3_rsz, r3_w, r3_p, r3_wn;
    t_off  r3_gsel;
    t_kind r3_kind;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pos0   <= r2_pos0;
            r3_pos1   <= r2_pos1;
            r3_baseao <= r2_baseao;
            r3_rsz    <= r2_rsz;
            r3_w      <= r2_w;
            r3_p      <= r2_p;
            r3_wn     <= c_bhi - r2_pos0;
            r3_gsel   <= r2_gsel;
            r3_kind   <= n_kind;
        end
    end

    // stage 4: final position and size, relative to the parent
    t_val n_pos, n_size;

    always_comb begin
        case (r3_kind)
            K_FLIP: begin
                n_pos  = r3_pos1;
                n_size = r3_w;
            end
            K_SLIDE_LO: begin
                n_pos  = c_b;
                n_size = r3_w;
            end
            K_SLIDE_HI: begin
                n_pos  = c_bhi - r3_w;
                n_size = r3_w;
            end
            K_RSZ_SLD: begin
                n_pos  = r3_rsz;
                n_size = c_bw;
            end
            K_RSZ_HI: begin
                n_pos  = r3_baseao - off_val(r3_gsel, r3_wn);
                n_size = r3_wn;
            end
            default: begin
                n_pos  = r3_pos0;
                n_size = r3_w;
            end
        endcase
    end

    t_val n_rel;
    assign n_rel = n_pos - r3_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos  <= n_rel[OW-1:0];
            o_size <= n_size[OW-1:0];
        end
    end

endmodule

/* dv/tb_popup_constraint_placement_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_popup_constraint_placement_core
// Self-checking bench for the popup placement core.
// ----------------------------------------------------------------------------
// Placement requests are driven, mostly with random gaps. Results are taken
// under random output stall, except in one calm phase, and compared field
// by field against a behavioral placement solver. The bounds registers are
// reprogrammed between phases, and only once the core has drained.
// ----------------------------------------------------------------------------
module tb_popup_constraint_placement_core;
    import pcp_pkg::*;

    localparam logic [3:0] EDGE_L = 4'd1;
    localparam logic [3:0] EDGE_R = 4'd2;
    localparam logic [3:0] EDGE_T = 4'd4;
    localparam logic [3:0] EDGE_B = 4'd8;

    // adjust flag bits
    localparam int AF_SLIDE_X  = 0;
    localparam int AF_SLIDE_Y  = 1;
    localparam int AF_FLIP_X   = 2;
    localparam int AF_FLIP_Y   = 3;
    localparam int AF_RESIZE_X = 4;
    localparam int AF_RESIZE_Y = 5;

    typedef struct packed {
        logic signed [15:0] parent_x, parent_y, anchor_rect_x, anchor_rect_y;
        logic [14:0]        anchor_rect_w, anchor_rect_h;
        logic signed [15:0] offset_x, offset_y;
        logic [14:0]        popup_w, popup_h;
        logic [7:0]         placement_codes;
        logic [5:0]         adjust_flags;
    } req_t;

    typedef struct packed {
        logic signed [OW-1:0] x, y, w, h;
    } rect_t;

    // bounds, mirrored from the register writes
    longint bnd_x, bnd_y, bnd_w, bnd_h;

    // working state of one placement
    typedef struct {
        longint px, py, ax, ay, aw, ah, ox, oy, x, y, w, h, sx, sy;
        logic [3:0] anc, grav;
    } plc_t;

    function automatic longint halve(longint v);
        return v / 2;   // SV division truncates toward zero
    endfunction

    function automatic logic [3:0] mirror_code(logic [3:0] c, bit fx, bit fy);
        if (fx) begin
            case (c)
                PC_LEFT: c = PC_RGT;
                PC_RGT:  c = PC_LEFT;
                PC_TL:   c = PC_TR;
                PC_TR:   c = PC_TL;
                PC_BL:   c = PC_BR;
                PC_BR:   c = PC_BL;
                default: ;
            endcase
        end
        if (fy) begin
            case (c)
                PC_TOP:  c = PC_BOT;
                PC_BOT:  c = PC_TOP;
                PC_TL:   c = PC_BL;
                PC_BL:   c = PC_TL;
                PC_TR:   c = PC_BR;
                PC_BR:   c = PC_TR;
                default: ;
            endcase
        end
        return c;
    endfunction

    function automatic void place(ref plc_t p);
        longint axo, ayo, gxo, gyo;
        axo = 0; ayo = 0; gxo = 0; gyo = 0;
        case (p.anc)
            PC_NONE: begin axo = halve(p.aw); ayo = halve(p.ah); end
            PC_TOP:  begin axo = halve(p.aw); ayo = 0; end
            PC_BOT:  begin axo = halve(p.aw); ayo = p.ah; end
            PC_LEFT: begin axo = 0; ayo = halve(p.ah); end
            PC_RGT:  begin axo = p.aw; ayo = halve(p.ah); end
            PC_TL:   begin axo = 0; ayo = 0; end
            PC_BL:   begin axo = 0; ayo = p.ah; end
            PC_TR:   begin axo = p.aw; ayo = 0; end
            PC_BR:   begin axo = p.aw; ayo = p.ah; end
            default: ;
        endcase
        case (p.grav)
            PC_NONE: begin gxo = halve(p.w); gyo = halve(p.h); end
            PC_TOP:  begin gxo = halve(p.w); gyo = p.h; end
            PC_BOT:  begin gxo = halve(p.w); gyo = 0; end
            PC_LEFT: begin gxo = p.w; gyo = halve(p.h); end
            PC_RGT:  begin gxo = 0; gyo = halve(p.h); end
            PC_TL:   begin gxo = p.w; gyo = p.h; end
            PC_BL:   begin gxo = p.w; gyo = 0; end
            PC_TR:   begin gxo = 0; gyo = p.h; end
            PC_BR:   begin gxo = 0; gyo = 0; end
            default: ;
        endcase
        p.x = p.px + axo - gxo + p.sx + p.ax + p.ox;
        p.y = p.py + ayo - gyo + p.sy + p.ay + p.oy;
    endfunction

    function automatic logic [3:0] violations(plc_t p);
        logic [3:0] e;
        e = '0;
        if (bnd_w > 0) begin
            if (p.x < bnd_x) e |= EDGE_L;
            if (p.x + p.w > bnd_x + bnd_w) e |= EDGE_R;
        end
        if (bnd_h > 0) begin
            if (p.y < bnd_y) e |= EDGE_T;
            if (p.y + p.h > bnd_y + bnd_h) e |= EDGE_B;
        end
        return e;
    endfunction

    function automatic void mirror(ref plc_t p, input bit fx, input bit fy);
        p.anc  = mirror_code(p.anc, fx, fy);
        p.grav = mirror_code(p.grav, fx, fy);
        place(p);
    endfunction

    function automatic void fit_y(ref plc_t p, input logic [3:0] e_in,
                                  input logic [5:0] f);
        logic [3:0] e;
        e = e_in;
        if (f[AF_FLIP_Y]) begin
            mirror(p, 0, 1);
            e = violations(p);
            if ((e & (EDGE_T | EDGE_B)) == 0) return;
            mirror(p, 0, 1);
            e = violations(p);
        end
        if (f[AF_SLIDE_Y] && (e & (EDGE_T | EDGE_B)) != (EDGE_T | EDGE_B)) begin
            if (e & EDGE_T) p.sy = bnd_y - p.y;
            else            p.sy = bnd_y + bnd_h - p.y - p.h;
            place(p);
            e = violations(p);
            if ((e & (EDGE_T | EDGE_B)) == 0) return;
            p.sy = 0;
            place(p);
            e = violations(p);
        end
        if (f[AF_RESIZE_Y]) begin
            if (f[AF_SLIDE_Y]) begin
                p.h = bnd_h;
                p.sy = bnd_y - p.y;
            end else if (e & EDGE_B) begin
                p.h = bnd_y + bnd_h - p.y;
            end
            place(p);
        end
    endfunction

    // full placement solve: X axis first, then Y with the edge set left over
    function automatic rect_t predict_rect(req_t r);
        plc_t p;
        logic [3:0] e;
        bit go_y;
        rect_t o;
        p.px = r.parent_x; p.py = r.parent_y;
        p.ax = r.anchor_rect_x; p.ay = r.anchor_rect_y;
        p.aw = r.anchor_rect_w; p.ah = r.anchor_rect_h;
        p.ox = r.offset_x; p.oy = r.offset_y;
        p.w = r.popup_w; p.h = r.popup_h;
        p.anc = r.placement_codes[3:0];
        p.grav = r.placement_codes[7:4];
        p.sx = 0; p.sy = 0;
        place(p);
        e = violations(p);
        go_y = 0;
        if (e != 0 && (e & (EDGE_L | EDGE_R))) begin
            if (r.adjust_flags[AF_FLIP_X]) begin
                mirror(p, 1, 0);
                e = violations(p);
                if (e == 0) go_y = 1;   // done, e empty skips Y
                else if ((e & (EDGE_L | EDGE_R)) == 0) go_y = 1;
                else begin
                    mirror(p, 1, 0);
                    e = violations(p);
                end
            end
            if (!go_y && r.adjust_flags[AF_SLIDE_X]
                && (e & (EDGE_L | EDGE_R)) != (EDGE_L | EDGE_R)) begin
                if (e & EDGE_L) p.sx = bnd_x - p.x;
                else            p.sx = bnd_x + bnd_w - p.x - p.w;
                place(p);
                e = violations(p);
                if ((e & (EDGE_L | EDGE_R)) == 0) go_y = 1;
                else begin
                    p.sx = 0;
                    place(p);
                    e = violations(p);
                end
            end
            if (!go_y && r.adjust_flags[AF_RESIZE_X]) begin
                if (r.adjust_flags[AF_SLIDE_X]) begin
                    p.w = bnd_w;
                    p.sx = bnd_x - p.x;
                end else if (e & EDGE_R) begin
                    p.w = bnd_x + bnd_w - p.x;
                end
                place(p);   // edge set stays stale on purpose
            end
        end
        if (e & (EDGE_T | EDGE_B)) fit_y(p, e, r.adjust_flags);
        o.x = OW'(p.x - p.px);
        o.y = OW'(p.y - p.py);
        o.w = OW'(p.w);
        o.h = OW'(p.h);
        return o;
    endfunction

    class placement_scoreboard;
        rect_t pending[$];
        int    errors = 0;

        function void note_request(req_t r);
            pending.push_back(predict_rect(r));
        endfunction

        function void check_rect(rect_t got);
            rect_t want;
            if (pending.size() == 0) begin
                $error("unexpected result word x=%0d y=%0d", got.x, got.y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $error("rect_x expected %0d got %0d", want.x, got.x); errors++;
            end
            if (got.y !== want.y) begin
                $error("rect_y expected %0d got %0d", want.y, got.y); errors++;
            end
            if (got.w !== want.w) begin
                $error("rect_w expected %0d got %0d", want.w, got.w); errors++;
            end
            if (got.h !== want.h) begin
                $error("rect_h expected %0d got %0d", want.h, got.h); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 0, o_in_stall;
    req_t req = '0;
    logic o_out_valid, i_out_stall = 1;
    logic signed [OW-1:0] o_rect_x, o_rect_y, o_rect_w, o_rect_h;

    placement_scoreboard sb = new();
    bit out_calm = 0;   // when set, output never stalls

    popup_constraint_placement_core i_dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall,
        .i_parent_x(req.parent_x), .i_parent_y(req.parent_y),
        .i_anchor_rect_x(req.anchor_rect_x), .i_anchor_rect_y(req.anchor_rect_y),
        .i_anchor_rect_w(req.anchor_rect_w), .i_anchor_rect_h(req.anchor_rect_h),
        .i_offset_x(req.offset_x), .i_offset_y(req.offset_y),
        .i_popup_w(req.popup_w), .i_popup_h(req.popup_h),
        .i_placement_codes(req.placement_codes), .i_adjust_flags(req.adjust_flags),
        .o_out_valid, .i_out_stall,
        .o_rect_x, .o_rect_y, .o_rect_w, .o_rect_h
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop: far beyond any correct run
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stall, check each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_rect('{o_rect_x, o_rect_y, o_rect_w, o_rect_h});
    end

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (out_calm) begin
                i_out_stall <= 0;
            end else begin
                n = gap_len();
                i_out_stall <= (n != 0);
                repeat (n) @(posedge i_clk);
                i_out_stall <= 0;
            end
        end
    end

    task automatic write_bound(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BX: bnd_x = longint'($signed(val));
            REG_BY: bnd_y = longint'($signed(val));
            REG_BW: bnd_w = longint'(val);
            default: bnd_h = longint'(val);
        endcase
        i_cfg_valid <= 0;
    endtask

    task automatic set_bounds(logic [15:0] bx, by, bw, bh);
        write_bound(REG_BX, bx);
        write_bound(REG_BY, by);
        write_bound(REG_BW, bw);
        write_bound(REG_BH, bh);
    endtask

    // present one word; hold it until the core takes it
    task automatic send(req_t r, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            i_in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1;
        req <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [3:0] rnd_code();
        return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
    endfunction

    // random request; wide mode hits full field ranges, otherwise a region
    // near the bounds so the flip, slide and resize paths get exercised
    function automatic req_t rnd_req(bit wide);
        req_t r;
        r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (!wide) begin
            r.parent_x = 16'($signed($urandom_range(0, 600)) - 300);
            r.parent_y = 16'($signed($urandom_range(0, 600)) - 300);
            r.anchor_rect_x = 16'($signed($urandom_range(0, 400)) - 200);
            r.anchor_rect_y = 16'($signed($urandom_range(0, 400)) - 200);
            r.anchor_rect_w = 15'($urandom_range(0, 120));
            r.anchor_rect_h = 15'($urandom_range(0, 120));
            r.offset_x = 16'($signed($urandom_range(0, 80)) - 40);
            r.offset_y = 16'($signed($urandom_range(0, 80)) - 40);
            r.popup_w = 15'($urandom_range(0, 500));
            r.popup_h = 15'($urandom_range(0, 500));
        end
        r.placement_codes = {rnd_code(), rnd_code()};
        return r;
    endfunction

    initial begin
        req_t r;
        int k;
        bnd_x = 0; bnd_y = 0; bnd_w = 0; bnd_h = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset bounds: nothing is constrained
        r = '0;
        send(r, 0);
        r = '1;
        r.adjust_flags = 6'h3F;
        send(r, 0);
        drain();

        // directed: sixteen anchor/gravity pairs, each with its own flag setting,
        // against a tight bounds box, then extreme fields
        set_bounds(16'hFF9C, 16'hFF9C, 16'd200, 16'd200);
        for (k = 0; k < 16; k++) begin
            r = '0;
            r.anchor_rect_w = 15'd61; r.anchor_rect_h = 15'd45;
            r.popup_w = 15'd151; r.popup_h = 15'd131;
            r.anchor_rect_x = 16'(k * 7 - 40);
            r.placement_codes = {4'(k), 4'(15 - k)};
            r.adjust_flags = 6'(k * 4 + (k & 3));
            send(r, 1);
        end
        r = '0;
        r.parent_x = 16'sh8000; r.parent_y = 16'sh7FFF;
        r.anchor_rect_x = 16'sh7FFF; r.anchor_rect_y = 16'sh8000;
        r.anchor_rect_w = '1; r.anchor_rect_h = '1;
        r.offset_x = 16'sh7FFF; r.offset_y = 16'sh8000;
        r.popup_w = '1; r.popup_h = '1;
        r.placement_codes = {PC_BR, PC_TL};
        r.adjust_flags = 6'h3F;
        send(r, 0);
        r.adjust_flags = 6'h30;
        send(r, 0);
        r.adjust_flags = 6'h0C;
        send(r, 0);

        // hold-off: let everything come back before the next word
        drain();
        r = rnd_req(0);
        send(r, 0);
        drain();

        // random phases over several bounds settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_bounds(16'hFF38, 16'hFF38, 16'd400, 16'd350);
                1: set_bounds(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
                2: set_bounds(16'h7FFF, 16'h7FFF, 16'd1, 16'd1);
                3: set_bounds(16'd0, 16'hFF00, 16'd0, 16'd300);
                4: set_bounds(16'hFE00, 16'd0, 16'd600, 16'd0);
                default: set_bounds(16'($urandom_range(0, 400) - 200),
                                    16'($urandom_range(0, 400) - 200),
                                    16'($urandom_range(1, 700)),
                                    16'($urandom_range(1, 700)));
            endcase
            out_calm = (ph == 2);
            for (k = 0; k < 145; k++) begin
                r = rnd_req($urandom_range(0, 5) == 0);
                send(r, (ph == 2) ? 0 : 1);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
